// ===== design/zbs_pkg.sv =====
`default_nettype none
package zbs_pkg;

    localparam int unsigned BYTE_BITS   = 8;
    localparam int unsigned RUN_LIMIT   = 5;
    localparam int unsigned MAX_RESULTS = 3;
    localparam int unsigned STUFF_BITS  = 10;   // 8 data bits plus at most two zeros
    localparam int unsigned PACK_BITS   = 17;   // 7 held bits plus a stuffed byte
    localparam int unsigned TOTAL_W     = 20;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'hFFFFF;
    localparam logic [3:0] FULL_COUNT = 4'd8;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic [3:0]         valid_bits;
        logic               last_out;
        logic [TOTAL_W-1:0] frame_bits;
    } t_result;

    // Results of one input byte, item[0] first; n is 1 to 3.
    typedef struct packed {
        t_result [MAX_RESULTS-1:0] item;
        logic [1:0]                n;
    } t_group;

endpackage
`default_nettype wire

// ===== design/zbs_stuff.sv =====
`default_nettype none
module zbs_stuff (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire logic [7:0]    i_data,
    input  wire logic          i_end,
    output zbs_pkg::t_group    o_group
);

    logic [2:0]                      r_ones_run;
    logic [6:0]                      r_pend_bits;
    logic [2:0]                      r_pend_cnt;
    logic [zbs_pkg::TOTAL_W-1:0]     r_total;

    logic [2:0]                      run;
    logic [zbs_pkg::STUFF_BITS-1:0]  stf;
    logic [3:0]                      pos;
    logic [zbs_pkg::PACK_BITS-1:0]   packed_bits;
    logic [4:0]                      total_cnt;
    logic [1:0]                      nfull;
    logic [6:0]                      n_pend_bits;
    logic [2:0]                      n_pend_cnt;
    logic [zbs_pkg::TOTAL_W:0]       sum;
    logic [zbs_pkg::TOTAL_W-1:0]     n_total;
    zbs_pkg::t_result                flush;

    // Serialize the byte LSB first, inserting a zero after five ones.
    always_comb begin
        run = r_ones_run;
        stf = '0;
        pos = '0;
        for (int i = 0; i < zbs_pkg::BYTE_BITS; i++) begin
            stf[pos] = i_data[i];
            pos      = pos + 4'd1;
            if (i_data[i]) begin
                if (run == 3'(zbs_pkg::RUN_LIMIT - 1)) begin
                    pos = pos + 4'd1;
                    run = '0;
                end else begin
                    run = run + 3'd1;
                end
            end else begin
                run = '0;
            end
        end
    end

    always_comb begin
        packed_bits = {10'b0, r_pend_bits}
                    | ({7'b0, stf} << r_pend_cnt);
        total_cnt   = {2'b0, r_pend_cnt} + {1'b0, pos};
        if (total_cnt >= 5'd16) begin
            nfull       = 2'd2;
            n_pend_bits = {6'b0, packed_bits[16]};
            n_pend_cnt  = 3'(total_cnt - 5'd16);
        end else if (total_cnt >= 5'd8) begin
            nfull       = 2'd1;
            n_pend_bits = packed_bits[14:8];
            n_pend_cnt  = 3'(total_cnt - 5'd8);
        end else begin
            nfull       = 2'd0;
            n_pend_bits = packed_bits[6:0];
            n_pend_cnt  = total_cnt[2:0];
        end
        sum     = {1'b0, r_total} + 21'(pos);
        n_total = (sum >= {1'b0, zbs_pkg::TOTAL_MAX}) ? zbs_pkg::TOTAL_MAX
                                                      : sum[zbs_pkg::TOTAL_W-1:0];
    end

    always_comb begin
        flush.out_byte   = {1'b0, n_pend_bits};
        flush.valid_bits = {1'b0, n_pend_cnt};
        flush.last_out   = 1'b1;
        flush.frame_bits = n_total;

        o_group        = '0;
        o_group.n      = nfull;
        o_group.item[0].out_byte   = packed_bits[7:0];
        o_group.item[0].valid_bits = zbs_pkg::FULL_COUNT;
        o_group.item[1].out_byte   = packed_bits[15:8];
        o_group.item[1].valid_bits = zbs_pkg::FULL_COUNT;
        if (nfull != 2'd2) begin
            o_group.item[1] = '0;
        end
        if (i_end) begin
            if (n_pend_cnt != 3'd0) begin
                o_group.n = nfull + 2'd1;
                case (nfull)
                    2'd0:    o_group.item[0] = flush;
                    2'd1:    o_group.item[1] = flush;
                    default: o_group.item[2] = flush;
                endcase
            end else begin
                // frame ends on a byte boundary: mark the last full byte
                case (nfull)
                    2'd2: begin
                        o_group.item[1].last_out   = 1'b1;
                        o_group.item[1].frame_bits = n_total;
                    end
                    default: begin
                        o_group.item[0].last_out   = 1'b1;
                        o_group.item[0].frame_bits = n_total;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ones_run  <= '0;
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
            r_total     <= '0;
        end else if (i_load) begin
            if (i_end) begin
                r_ones_run  <= '0;
                r_pend_bits <= '0;
                r_pend_cnt  <= '0;
                r_total     <= '0;
            end else begin
                r_ones_run  <= run;
                r_pend_bits <= n_pend_bits;
                r_pend_cnt  <= n_pend_cnt;
                r_total     <= n_total;
            end
        end
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && i_end) |=> (r_ones_run == 3'd0 && r_pend_cnt == 3'd0
                               && r_total == '0))
        else $error("frame state not cleared after frame end");

    a_group_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (o_group.n != 2'd0))
        else $error("input byte produced no result");

endmodule
`default_nettype wire

// ===== design/zbs_outbuf.sv =====
`default_nettype none
module zbs_outbuf (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire zbs_pkg::t_group i_group,
    output logic                 o_can_load,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output zbs_pkg::t_result     o_item
);

    zbs_pkg::t_result [zbs_pkg::MAX_RESULTS-1:0] r_items;
    logic [1:0]                                  r_cnt;
    logic                                        take;

    assign o_valid    = (r_cnt != 2'd0);
    assign take       = o_valid && i_ready;
    assign o_can_load = (r_cnt == 2'd0) || (r_cnt == 2'd1 && take);
    assign o_item     = r_items[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_group.n;
        end else if (take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // advance the queue one item per taken beat
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_items <= i_group.item;
        end else if (take) begin
            r_items[0] <= r_items[1];
            r_items[1] <= r_items[2];
        end
    end

    a_last_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > 2'd1) |-> !r_items[0].last_out)
        else $error("last_out ahead of remaining results");

    a_mid_total_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_item.last_out) |-> (o_item.frame_bits == '0))
        else $error("frame_bits nonzero on a non-final beat");

    a_mid_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_item.last_out) |-> (o_item.valid_bits == zbs_pkg::FULL_COUNT))
        else $error("partial byte before frame end");

endmodule
`default_nettype wire

// ===== design/zero_bit_stuffer.sv =====
// Channel   Direction  tdata (low bit up)                         tlast
// s_axis    in         data_byte[7:0]                             frame_end
// m_axis    out        out_byte[7:0] valid_bits[11:8]             last_out
//                      frame_bits[31:12]
//
// Each byte is held in an input register, stuffed in one pass of logic and
// loaded as a group of one to three results into the output queue.
// A byte yields one or two results, three only at a frame end with a partial
// byte; the output port sends one beat per cycle while tready is held high.
// Reset (synchronous, active low) empties both registers and clears the state.
// A stalled output holds the queue; tready drops until its final beat is taken.
`default_nettype none
module zero_bit_stuffer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // data_byte
    input  wire logic        i_s_axis_tlast,   // frame_end
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // out_byte, valid_bits, frame_bits
    output logic             o_m_axis_tlast    // last_out
);

    logic             r_in_valid;
    logic [7:0]       r_in_data;
    logic             r_in_end;
    logic             can_load;
    logic             load;
    zbs_pkg::t_group  group;
    zbs_pkg::t_result item;

    // move the held byte on whenever the queue will be empty
    assign load            = r_in_valid && can_load;
    assign o_s_axis_tready = !r_in_valid || load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_data <= i_s_axis_tdata;
            r_in_end  <= i_s_axis_tlast;
        end
    end

    zbs_stuff u_stuff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_data  (r_in_data),
        .i_end   (r_in_end),
        .o_group (group)
    );

    zbs_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_group    (group),
        .o_can_load (can_load),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_item     (item)
    );

    assign o_m_axis_tdata = {item.frame_bits, item.valid_bits, item.out_byte};
    assign o_m_axis_tlast = item.last_out;

endmodule
`default_nettype wire

// ===== tb/sv/tb_zero_bit_stuffer.sv =====
`default_nettype none
module tb_zero_bit_stuffer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 300;      // long receiver hold-off
    localparam int DRAIN_CYCLES = 16;       // margin to watch for stray beats
    localparam int MAX_REPORTS  = 10;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [7:0]  i_s_axis_tdata  = '0;      // data_byte
    logic        i_s_axis_tlast  = 1'b0;    // frame_end
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;            // out_byte, valid_bits, frame_bits
    logic        o_m_axis_tlast;            // last_out

    zero_bit_stuffer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Stuffing predictor: its own copy of the line state
    // ------------------------------------------------------------------
    int                          run_ones   = 0;    // consecutive ones on the line, 0..4
    logic [16:0]                 hold_bits  = '0;   // stuffed bits not yet packed out
    int                          hold_cnt   = 0;
    logic [zbs_pkg::TOTAL_W-1:0] line_total = '0;   // stuffed bits of the current frame
    zbs_pkg::t_result            stuffed_q [$];     // expected output beats, oldest first

    int  err_count    = 0;
    int  cycle_count  = 0;
    bit  src_idle_en  = 1'b1;
    bit  sink_idle_en = 1'b1;
    bit  hold_flip    = 1'b0;              // toggle to request a long hold-off

    // Append one bit to the line and bump the saturating frame total.
    function automatic void put_line_bit(input logic b);
        hold_bits[hold_cnt] = b;
        hold_cnt++;
        if (line_total != zbs_pkg::TOTAL_MAX) line_total++;
    endfunction

    // Work out the beats one accepted byte causes and queue them.
    function automatic void stuff_byte(input logic [7:0] data, input logic last);
        zbs_pkg::t_result beats [$];
        zbs_pkg::t_result one;
        int               i;
        for (i = 0; i < zbs_pkg::BYTE_BITS; i++) begin
            put_line_bit(data[i]);
            if (data[i]) begin
                run_ones++;
                // insert a zero after five ones, even on the frame's last bit
                if (run_ones >= zbs_pkg::RUN_LIMIT) begin
                    put_line_bit(1'b0);
                    run_ones = 0;
                end
            end else begin
                run_ones = 0;
            end
        end
        while (hold_cnt >= zbs_pkg::BYTE_BITS) begin
            one            = '0;
            one.out_byte   = hold_bits[7:0];
            one.valid_bits = zbs_pkg::FULL_COUNT;
            beats.push_back(one);
            hold_bits = hold_bits >> zbs_pkg::BYTE_BITS;
            hold_cnt  -= zbs_pkg::BYTE_BITS;
        end
        if (last) begin
            if (hold_cnt > 0) begin
                // flush the partial byte; bits above hold_cnt are already zero
                one            = '0;
                one.out_byte   = hold_bits[7:0];
                one.valid_bits = hold_cnt[3:0];
                one.last_out   = 1'b1;
                one.frame_bits = line_total;
                beats.push_back(one);
            end else if (beats.size() > 0) begin
                // frame ends on a byte boundary: tag the last full byte
                beats[beats.size()-1].last_out   = 1'b1;
                beats[beats.size()-1].frame_bits = line_total;
            end
            run_ones   = 0;
            hold_bits  = '0;
            hold_cnt   = 0;
            line_total = '0;
        end
        foreach (beats[k]) stuffed_q.push_back(beats[k]);
    endfunction

    // ------------------------------------------------------------------
    // Sender: offer one byte, hold it until the beat is taken
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] data, input logic last);
        if (src_idle_en && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= data;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        stuff_byte(data, last);
    endtask

    // Bytes rich in ones so that stuffing happens often.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 3))
            0:       return 8'hFF;
            1:       return 8'($urandom | $urandom);
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_frame(input int len);
        int k;
        for (k = 0; k < len; k++) send_byte(pick_byte(), k == len - 1);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus a long hold-off on request
    // ------------------------------------------------------------------
    bit hold_seen  = 1'b0;
    int hold_left  = 0;
    int stall_left = 0;

    always @(posedge i_clk) begin
        if (hold_flip != hold_seen) begin
            hold_seen = hold_flip;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 16) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Checker: compare every output beat with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_beats
        zbs_pkg::t_result got;
        zbs_pkg::t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.out_byte   = o_m_axis_tdata[7:0];
            got.valid_bits = o_m_axis_tdata[11:8];
            got.last_out   = o_m_axis_tlast;
            got.frame_bits = o_m_axis_tdata[31:12];
            if (stuffed_q.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("unexpected beat: byte %02h bits %0d last %0b total %0d",
                             got.out_byte, got.valid_bits, got.last_out, got.frame_bits);
            end else begin
                want = stuffed_q.pop_front();
                if (got !== want) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("mismatch: exp byte %02h bits %0d last %0b total %0d, %s",
                                 want.out_byte, want.valid_bits, want.last_out,
                                 want.frame_bits,
                                 $sformatf("got byte %02h bits %0d last %0b total %0d",
                                           got.out_byte, got.valid_bits, got.last_out,
                                           got.frame_bits));
                end
            end
        end
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked frames: all zeros and all ones, five ones at either end of a
    // byte, a frame ending on a byte boundary, runs crossing byte borders.
    task automatic test_directed();
        logic [8:0] steps [$];   // {frame_end, data_byte}
        steps = '{9'h100, 9'h1FF, 9'h1F8, 9'h11F,
                  9'h0FF, 9'h0FF, 9'h0FF, 9'h1FF,
                  9'h055, 9'h1AA,
                  9'h000, 9'h000, 9'h100,
                  9'h07C, 9'h03E, 9'h180,
                  9'h001, 9'h1FE,
                  9'h0F0, 9'h00F, 9'h1E7};
        foreach (steps[k]) send_byte(steps[k][7:0], steps[k][8]);
    endtask

    // Random frames, mostly short, now and then longer.
    task automatic test_random_frames(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 20)
                                              : $urandom_range(1, 8);
            send_frame(len);
            sent += len;
        end
    endtask

    // Hold the receiver off while bytes keep coming, so the output queue and
    // the input register fill and tready drops.
    task automatic test_backpressure();
        src_idle_en = 1'b0;
        hold_flip <= ~hold_flip;
        send_frame(12);
        send_frame(12);
        src_idle_en = 1'b1;
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_streaming();
        src_idle_en = 1'b0;
        sink_idle_en <= 1'b0;
        test_random_frames(20);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_frames(40);
        test_backpressure();
        test_streaming();

        // drop valid, let every expected beat arrive, then watch for strays
        i_s_axis_tvalid <= 1'b0;
        while (stuffed_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0 && stuffed_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/zbs_pkg.sv
design/zbs_stuff.sv
design/zbs_outbuf.sv
design/zero_bit_stuffer.sv
tb/sv/tb_zero_bit_stuffer.sv
